FILE: hdl/u8u16_pkg.sv
package u8u16_pkg;

    // Input request: one byte of the UTF-8 string
    typedef struct packed {
        logic [7:0] in_byte;
        logic       last_byte;
    } in_item_t;

    // Output request: one UTF-16 code unit
    typedef struct packed {
        logic [15:0] code_unit;
        logic        is_replacement;
        logic        last_unit;
        logic        end_of_string;
    } out_item_t;

    localparam logic [15:0] REPL_UNIT    = 16'hFFFD;
    localparam logic [5:0]  HI_SURR_TAG  = 6'b110110;   // 0xD800 >> 10
    localparam logic [5:0]  LO_SURR_TAG  = 6'b110111;   // 0xDC00 >> 10
    localparam logic [20:0] SURR_FIRST   = 21'h00D800;
    localparam logic [20:0] SURR_LAST    = 21'h00DFFF;
    localparam logic [20:0] MIN_TWO      = 21'h000080;
    localparam logic [20:0] MIN_THREE    = 21'h000800;
    localparam logic [20:0] MIN_FOUR     = 21'h010000;
    localparam logic [20:0] MAX_CP       = 21'h10FFFF;

    // Most units one input byte can produce
    localparam int unsigned MAX_UNITS = 4;

endpackage

FILE: hdl/utf8_to_utf16_transcoder.sv
// UTF-8 to UTF-16 transcoder. Bytes enter one per request with last_byte marking the end
// of a string; UTF-16 units leave one per request, with last_unit on the final unit a
// byte caused and end_of_string on the final unit of the string. Invalid leads, broken,
// overlong, surrogate and out-of-range sequences and strings that end mid-sequence give one
// U+FFFD (is_replacement = 1) per offending byte. A byte is taken into an input register,
// decoded into a list of up to four units held in the result registers, and the list
// drains through the output port one unit per cycle while out_ready is high. Throughput
// is one byte per cycle while each byte yields at most one unit and the output does not
// stall; a byte that yields several units holds back the following byte until its last
// unit is taken. Bytes that only extend an open sequence produce no unit.
module utf8_to_utf16_transcoder (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  u8u16_pkg::in_item_t   in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output u8u16_pkg::out_item_t  out_data
);

    typedef enum logic [2:0] {
        LEAD_ASCII,
        LEAD_TWO,
        LEAD_THREE,
        LEAD_FOUR,
        LEAD_BAD
    } lead_t;

    // Input register
    logic                 in_v_reg;
    u8u16_pkg::in_item_t  in_data_reg;

    // Decoder state
    logic [20:0] pv_reg, pv_next;
    logic [2:0]  el_reg, el_next;
    logic [2:0]  bh_reg, bh_next;

    // Result list
    logic [15:0] unit_reg [u8u16_pkg::MAX_UNITS];
    logic [15:0] unit_next [u8u16_pkg::MAX_UNITS];
    logic [3:0]  rep_reg, rep_next;
    logic [2:0]  cnt_reg, cnt_next;
    logic [1:0]  idx_reg;
    logic        eos_reg;

    // Decode signals
    logic [7:0]  b;
    logic        last;
    logic        cont;
    lead_t       lead_cls;
    logic [20:0] pv_acc;
    logic [2:0]  bh_acc;
    logic        cp_ok;
    logic [19:0] pair_v;
    logic [2:0]  fl;
    logic [1:0]  tail_n;
    logic [15:0] t0, t1;
    logic        t0_rep;

    logic out_last;
    logic out_fire;
    logic list_done;
    logic decode_go;

    // Handshake
    assign out_valid = (cnt_reg != 3'd0);
    assign out_last  = ({1'b0, idx_reg} == (cnt_reg - 3'd1));
    assign out_fire  = out_valid && out_ready;
    assign list_done = !out_valid || (out_fire && out_last);
    assign decode_go = in_v_reg && list_done;
    assign in_ready  = !in_v_reg || decode_go;

    assign out_data.code_unit      = unit_reg[idx_reg];
    assign out_data.is_replacement = rep_reg[idx_reg];
    assign out_data.last_unit      = out_last;
    assign out_data.end_of_string  = out_last && eos_reg;

    // Byte decode and sequence check
    always_comb
    begin
        b      = in_data_reg.in_byte;
        last   = in_data_reg.last_byte;
        cont   = (b[7:6] == 2'b10);
        pv_acc = {pv_reg[14:0], b[5:0]};
        bh_acc = bh_reg + 3'd1;
        pair_v = 20'(pv_acc - u8u16_pkg::MIN_FOUR);

        unique case (b) inside
            [8'h00:8'h7F]: lead_cls = LEAD_ASCII;
            [8'hC0:8'hDF]: lead_cls = LEAD_TWO;
            [8'hE0:8'hEF]: lead_cls = LEAD_THREE;
            [8'hF0:8'hF7]: lead_cls = LEAD_FOUR;
            default:       lead_cls = LEAD_BAD;
        endcase

        unique case (el_reg)
            3'd2:    cp_ok = (pv_acc >= u8u16_pkg::MIN_TWO);
            3'd3:    cp_ok = (pv_acc >= u8u16_pkg::MIN_THREE)
                             && !((pv_acc >= u8u16_pkg::SURR_FIRST)
                                  && (pv_acc <= u8u16_pkg::SURR_LAST));
            default: cp_ok = (pv_acc >= u8u16_pkg::MIN_FOUR)
                             && (pv_acc <= u8u16_pkg::MAX_CP);
        endcase

        fl      = 3'd0;
        tail_n  = 2'd0;
        t0      = {8'h00, b};
        t1      = {u8u16_pkg::LO_SURR_TAG, pair_v[9:0]};
        t0_rep  = 1'b0;
        pv_next = pv_reg;
        el_next = el_reg;
        bh_next = bh_reg;

        if ((el_reg != 3'd0) && cont)
        begin
            // continuation of an open sequence
            pv_next = pv_acc;
            bh_next = bh_acc;
            if (bh_acc >= el_reg)
            begin
                pv_next = 21'd0;
                el_next = 3'd0;
                bh_next = 3'd0;
                if (!cp_ok)
                begin
                    fl = bh_acc;
                end
                else if (pv_acc[20:16] == 5'd0)
                begin
                    tail_n = 2'd1;
                    t0     = pv_acc[15:0];
                end
                else
                begin
                    tail_n = 2'd2;
                    t0     = {u8u16_pkg::HI_SURR_TAG, pair_v[19:10]};
                end
            end
        end
        else
        begin
            // broken sequence: flush held bytes, then treat byte as a lead
            if (el_reg != 3'd0)
            begin
                fl = bh_reg;
            end
            pv_next = 21'd0;
            el_next = 3'd0;
            bh_next = 3'd0;
            unique case (lead_cls)
                LEAD_ASCII:
                begin
                    tail_n = 2'd1;
                end
                LEAD_TWO:
                begin
                    pv_next = {16'd0, b[4:0]};
                    el_next = 3'd2;
                    bh_next = 3'd1;
                end
                LEAD_THREE:
                begin
                    pv_next = {17'd0, b[3:0]};
                    el_next = 3'd3;
                    bh_next = 3'd1;
                end
                LEAD_FOUR:
                begin
                    pv_next = {18'd0, b[2:0]};
                    el_next = 3'd4;
                    bh_next = 3'd1;
                end
                default:
                begin
                    tail_n = 2'd1;
                    t0     = u8u16_pkg::REPL_UNIT;
                    t0_rep = 1'b1;
                end
            endcase
        end

        // end of string: flush whatever is still open
        if (last)
        begin
            if (el_next != 3'd0)
            begin
                fl = fl + bh_next;
            end
            pv_next = 21'd0;
            el_next = 3'd0;
            bh_next = 3'd0;
        end

        cnt_next = fl + {1'b0, tail_n};

        // replacements first, then the tail units
        for (int k = 0; k < u8u16_pkg::MAX_UNITS; k++)
        begin
            if (3'(k) < fl)
            begin
                unit_next[k] = u8u16_pkg::REPL_UNIT;
                rep_next[k]  = 1'b1;
            end
            else if (3'(k) == fl)
            begin
                unit_next[k] = t0;
                rep_next[k]  = t0_rep;
            end
            else
            begin
                unit_next[k] = t1;
                rep_next[k]  = 1'b0;
            end
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_v_reg <= 1'b0;
            pv_reg   <= 21'd0;
            el_reg   <= 3'd0;
            bh_reg   <= 3'd0;
            cnt_reg  <= 3'd0;
            idx_reg  <= 2'd0;
        end
        else
        begin
            if (in_ready)
            begin
                in_v_reg <= in_valid;
            end
            if (decode_go)
            begin
                pv_reg  <= pv_next;
                el_reg  <= el_next;
                bh_reg  <= bh_next;
                cnt_reg <= cnt_next;
                idx_reg <= 2'd0;
            end
            else if (out_fire)
            begin
                if (out_last)
                begin
                    cnt_reg <= 3'd0;
                    idx_reg <= 2'd0;
                end
                else
                begin
                    idx_reg <= idx_reg + 2'd1;
                end
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_data_reg <= in_data;
        end
        if (decode_go)
        begin
            unit_reg <= unit_next;
            rep_reg  <= rep_next;
            eos_reg  <= last;
        end
    end

endmodule

FILE: hdl/u8u16_checker.sv
module u8u16_checker (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  out_valid,
    input logic                  out_ready,
    input u8u16_pkg::out_item_t  out_data
);

    // A pending unit holds until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("output request dropped or changed while stalled");

    // End of string only on the last unit of a byte
    a_eos_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.end_of_string |-> out_data.last_unit)
        else $error("end_of_string without last_unit");

    // Replacements always carry U+FFFD
    a_rep_unit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.is_replacement |-> out_data.code_unit == u8u16_pkg::REPL_UNIT)
        else $error("replacement flag on a unit other than U+FFFD");

    // A decoded high surrogate is never the last unit of its byte
    a_pair: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.is_replacement
        && out_data.code_unit[15:10] == u8u16_pkg::HI_SURR_TAG |-> !out_data.last_unit)
        else $error("high surrogate not followed by its pair");

    // Units of one byte leave back to back
    a_list_cont: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !out_data.last_unit |=> out_valid)
        else $error("gap inside the unit list of one byte");

endmodule

bind utf8_to_utf16_transcoder u8u16_checker u_u8u16_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

FILE: verif/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int unsigned STALL_LIMIT  = 2000;  // cycles with no request accepted
    localparam int unsigned HOLD_CYCLES  = 300;   // long output back-pressure
    localparam int unsigned DRAIN_CYCLES = 20;

    // Tracks the decoder state and queues the UTF-16 units each byte should produce
    class utf16_scoreboard;
        u8u16_pkg::out_item_t expected_units[$];
        u8u16_pkg::out_item_t step_units[$];
        logic [20:0] cp_acc = '0;
        logic [2:0]  seq_len = '0;
        logic [2:0]  seq_held = '0;
        int unsigned mismatches = 0;

        function string show(u8u16_pkg::out_item_t u);
            return $sformatf("unit=%h repl=%b last_unit=%b eos=%b",
                             u.code_unit, u.is_replacement, u.last_unit, u.end_of_string);
        endfunction

        function void emit(logic [15:0] unit, logic repl);
            u8u16_pkg::out_item_t u;
            u = '0;
            u.code_unit = unit;
            u.is_replacement = repl;
            if (step_units.size() < u8u16_pkg::MAX_UNITS)
                step_units.push_back(u);
        endfunction

        function void close_seq();
            cp_acc = '0;
            seq_len = '0;
            seq_held = '0;
        endfunction

        // one replacement per byte held in the open sequence
        function void flush_held();
            for (int k = 0; k < seq_held && k < u8u16_pkg::MAX_UNITS; k++)
                emit(u8u16_pkg::REPL_UNIT, 1'b1);
            close_seq();
        endfunction

        function void start_seq(logic [7:0] b);
            if (b[7] == 1'b0)
                emit({8'h00, b}, 1'b0);
            else if (b[7:5] == 3'b110)
            begin
                cp_acc = {16'b0, b[4:0]};
                seq_len = 3'd2;
                seq_held = 3'd1;
            end
            else if (b[7:4] == 4'b1110)
            begin
                cp_acc = {17'b0, b[3:0]};
                seq_len = 3'd3;
                seq_held = 3'd1;
            end
            else if (b[7:3] == 5'b11110)
            begin
                cp_acc = {18'b0, b[2:0]};
                seq_len = 3'd4;
                seq_held = 3'd1;
            end
            else
                emit(u8u16_pkg::REPL_UNIT, 1'b1);
        endfunction

        // complete sequence: reject overlong, surrogate and out-of-range values
        function void finish_seq();
            logic        ok;
            logic [20:0] offs;
            case (seq_len)
                3'd2:    ok = cp_acc >= u8u16_pkg::MIN_TWO;
                3'd3:    ok = cp_acc >= u8u16_pkg::MIN_THREE &&
                              !(cp_acc >= u8u16_pkg::SURR_FIRST &&
                                cp_acc <= u8u16_pkg::SURR_LAST);
                default: ok = cp_acc >= u8u16_pkg::MIN_FOUR && cp_acc <= u8u16_pkg::MAX_CP;
            endcase
            if (!ok)
                flush_held();
            else
            begin
                if (cp_acc <= 21'h00FFFF)
                    emit(cp_acc[15:0], 1'b0);
                else
                begin
                    offs = cp_acc - u8u16_pkg::MIN_FOUR;
                    emit({u8u16_pkg::HI_SURR_TAG, offs[19:10]}, 1'b0);
                    emit({u8u16_pkg::LO_SURR_TAG, offs[9:0]}, 1'b0);
                end
                close_seq();
            end
        endfunction

        function void note_request(u8u16_pkg::in_item_t req);
            u8u16_pkg::out_item_t u;
            step_units.delete();
            if (seq_len == 0)
                start_seq(req.in_byte);
            else if (req.in_byte[7:6] == 2'b10)
            begin
                cp_acc = {cp_acc[14:0], req.in_byte[5:0]};
                seq_held = seq_held + 3'd1;
                if (seq_held >= seq_len)
                    finish_seq();
            end
            else
            begin
                // broken sequence: flush, then decode this byte as a new lead
                flush_held();
                start_seq(req.in_byte);
            end
            if (req.last_byte)
            begin
                if (seq_len != 0)
                    flush_held();
                close_seq();
            end
            foreach (step_units[k])
            begin
                u = step_units[k];
                u.last_unit = (k == step_units.size() - 1);
                u.end_of_string = u.last_unit && req.last_byte;
                expected_units.push_back(u);
            end
        endfunction

        function void check_unit(u8u16_pkg::out_item_t got);
            u8u16_pkg::out_item_t want;
            if (expected_units.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected unit, expected none, actual %s", $time, show(got));
                return;
            end
            want = expected_units.pop_front();
            if (got.code_unit !== want.code_unit || got.is_replacement !== want.is_replacement ||
                got.last_unit !== want.last_unit || got.end_of_string !== want.end_of_string)
            begin
                mismatches++;
                $display("%0t: mismatch, expected %s, actual %s",
                         $time, show(want), show(got));
            end
        endfunction
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    u8u16_pkg::in_item_t  in_data = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    u8u16_pkg::out_item_t out_data;

    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned hold_left = 0;
    bit          hold_request = 1'b0;
    int unsigned quiet_cycles = 0;

    utf16_scoreboard sb = new;

    always #5 clk = ~clk;

    utf8_to_utf16_transcoder u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // Monitor: accepted requests on both channels
    always @(posedge clk)
    begin
        if (in_valid && in_ready)
            sb.note_request(in_data);
        if (out_valid && out_ready)
            sb.check_unit(out_data);
    end

    // Watchdog on cycles with no request accepted
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("utf8_to_utf16_transcoder verification failed");
            $finish;
        end
    end

    // Receiver: random stalls, plus one long hold-off on request
    always @(negedge clk)
    begin
        if (hold_request)
        begin
            hold_request = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left != 0)
        begin
            hold_left--;
            out_ready = 1'b0;
        end
        else
            out_ready = ($urandom_range(99) >= recv_idle_pct);
    end

    // Sender: called at a falling edge, returns at the falling edge after acceptance
    task automatic send_request(input logic [7:0] octet, input logic last_flag);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_data.in_byte = octet;
        in_data.last_byte = last_flag;
        in_valid = 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Random strings: mostly encoded code points, some truncated, some noise bytes
    task automatic run_random(input int unsigned n_items);
        int unsigned sent;
        int unsigned kind;
        int unsigned nbytes;
        int unsigned keep;
        logic [20:0] cp;
        logic [7:0]  enc [4];
        logic [7:0]  utf8_text [$];
        sent = 0;
        while (sent < n_items)
        begin
            utf8_text.delete();
            repeat ($urandom_range(1, 6))
            begin
                kind = $urandom_range(99);
                if (kind < 10)
                    utf8_text.push_back(8'($urandom));
                else
                begin
                    nbytes = $urandom_range(1, 4);
                    case (nbytes)
                        1: cp = 21'($urandom_range(0, 'h7F));
                        2: cp = 21'($urandom_range(0, 'h7FF));
                        3: cp = 21'($urandom_range(0, 'hFFFF));
                        default: cp = ($urandom_range(3) == 0) ? 21'($urandom) :
                                      21'('h10000 + $urandom_range(0, 'hFFFFF));
                    endcase
                    enc[1] = {2'b10, cp[5:0]};
                    case (nbytes)
                        1: enc[0] = {1'b0, cp[6:0]};
                        2: enc[0] = {3'b110, cp[10:6]};
                        3:
                        begin
                            enc[0] = {4'b1110, cp[15:12]};
                            enc[1] = {2'b10, cp[11:6]};
                            enc[2] = {2'b10, cp[5:0]};
                        end
                        default:
                        begin
                            enc[0] = {5'b11110, cp[20:18]};
                            enc[1] = {2'b10, cp[17:12]};
                            enc[2] = {2'b10, cp[11:6]};
                            enc[3] = {2'b10, cp[5:0]};
                        end
                    endcase
                    // some sequences are cut short
                    keep = (kind < 25) ? $urandom_range(1, nbytes) : nbytes;
                    for (int k = 0; k < keep; k++)
                        utf8_text.push_back(enc[k]);
                end
            end
            foreach (utf8_text[k])
            begin
                send_request(utf8_text[k], k == utf8_text.size() - 1);
                sent++;
            end
        end
    endtask

    initial
    begin
        // {last_byte, in_byte}
        logic [8:0] directed_seq [27] = '{
            9'h000, 9'h07F,                    // zero byte, top ASCII
            9'h0C2, 9'h080,                    // U+0080
            9'h0C0, 9'h080,                    // overlong two-byte
            9'h0EF, 9'h0BF, 9'h0BD,            // encoded U+FFFD, not a replacement
            9'h0ED, 9'h0A0, 9'h080,            // surrogate
            9'h0F4, 9'h08F, 9'h0BF, 9'h0BF,    // U+10FFFF, surrogate pair
            9'h0F4, 9'h090, 9'h080, 9'h080,    // above U+10FFFF, four replacements
            9'h080, 9'h0FF,                    // invalid leads
            9'h0E2, 9'h041,                    // broken sequence then 'A'
            9'h0F0, 9'h190,                    // unfinished at end of string
            9'h141                             // one-byte string
        };

        send_idle_pct = 26;
        recv_idle_pct = 70;
        repeat (9)
            @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (directed_seq[i])
            send_request(directed_seq[i][7:0], directed_seq[i][8]);
        run_random(130);

        send_idle_pct = 70;
        recv_idle_pct = 26;
        run_random(130);

        // no idling; the receiver holds off long enough to back up the input
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_request = 1'b1;
        run_random(125);
        in_valid = 1'b0;

        while (sb.expected_units.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);

        if (sb.mismatches == 0 && sb.expected_units.size() == 0)
            $display("utf8_to_utf16_transcoder verification clean");
        else
            $display("utf8_to_utf16_transcoder verification failed");
        $finish;
    end

endmodule
